@@ rtl/rld_pkg.sv @@
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the bit-packed run-length decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

    // Token layout: 1-bit kind, then count minus one
    localparam int COUNT_BITS = 6;
    localparam int HDR_BITS   = COUNT_BITS + 1;
    localparam int BYTE_BITS  = 8;
    localparam int CNT_W      = COUNT_BITS + 1;            // holds a full run length
    localparam int HELD_W     = $clog2(BYTE_BITS + 1);

    // Command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // Token parser phase
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_RUN
    } t_phase;

    // One output command: a byte repeated count times, or an end-only marker
    typedef struct packed {
        logic                 has_data;
        logic [BYTE_BITS-1:0] data;
        logic [CNT_W-1:0]     count;
        logic                 eos;
    } t_cmd;

    // Queue status seen by its two users
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ rtl/rld_front.sv @@
// ----------------------------------------------------------------------------
// rld_front
// Parses one compressed byte per transfer into at most one output command.
// ----------------------------------------------------------------------------
module rld_front
    import rld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_BITS-1:0] i_code_byte,
    input  t_qstat               i_qstat,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [BYTE_BITS-1:0] r_store, n_store;
    logic [HELD_W-1:0]    r_held,  n_held;
    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_left,  n_left;
    logic                 r_done,  n_done;

    logic                 ev;
    logic [BYTE_BITS-1:0] ev_val;
    logic [CNT_W-1:0]     ev_cnt;
    logic                 ended;
    logic                 in_fire;

    // After the end marker every byte is taken and dropped
    assign o_in_ready = r_done | ~i_qstat.full;
    assign in_fire    = i_in_valid & o_in_ready;

    // Next state: walk the eight bits of the byte, MSB first
    always_comb begin
        logic [BYTE_BITS-1:0] s;
        logic [HELD_W-1:0]    h;
        t_phase               ph;
        logic [CNT_W-1:0]     left;
        s      = r_store;
        h      = r_held;
        ph     = r_phase;
        left   = r_left;
        ended  = 1'b0;
        ev     = 1'b0;
        ev_val = '0;
        ev_cnt = '0;
        for (int b = BYTE_BITS - 1; b >= 0; b--) begin
            if (!ended) begin
                s = {s[BYTE_BITS-2:0], i_code_byte[b]};
                h = h + HELD_W'(1);
                case (ph)
                    PH_LITERAL: begin
                        if (h == HELD_W'(BYTE_BITS)) begin
                            ev     = 1'b1;
                            ev_val = s;
                            ev_cnt = CNT_W'(1);
                            s      = '0;
                            h      = '0;
                            left   = left - CNT_W'(1);
                            if (left == '0) ph = PH_HEADER;
                        end
                    end
                    PH_RUN: begin
                        if (h == HELD_W'(BYTE_BITS)) begin
                            ev     = 1'b1;
                            ev_val = s;
                            ev_cnt = left;
                            s      = '0;
                            h      = '0;
                            left   = '0;
                            ph     = PH_HEADER;
                        end
                    end
                    default: begin
                        ph = PH_HEADER;
                        if (h == HELD_W'(HDR_BITS)) begin
                            // kind 1 with zero count field is the end marker
                            if (s[COUNT_BITS] && (s[COUNT_BITS-1:0] == '0)) begin
                                ended = 1'b1;
                            end else begin
                                left = CNT_W'(s[COUNT_BITS-1:0]) + CNT_W'(1);
                                ph   = s[COUNT_BITS] ? PH_RUN : PH_LITERAL;
                            end
                            s = '0;
                            h = '0;
                        end
                    end
                endcase
            end
        end
        n_store = s;
        n_held  = h;
        n_phase = ph;
        n_left  = left;
        n_done  = ended;
    end

    // Outputs: one command per byte that completes data or the end marker
    always_comb begin
        o_push = in_fire & ~r_done & (ev | ended);
        if (ev) begin
            o_cmd.has_data = 1'b1;
            o_cmd.data     = ev_val;
            o_cmd.count    = ev_cnt;
        end else begin
            o_cmd.has_data = 1'b0;
            o_cmd.data     = '0;
            o_cmd.count    = CNT_W'(1);
        end
        o_cmd.eos = ended;
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_held  <= '0;
            r_phase <= PH_HEADER;
            r_left  <= '0;
            r_done  <= 1'b0;
        end else if (in_fire && !r_done) begin
            r_store <= n_store;
            r_held  <= n_held;
            r_phase <= n_phase;
            r_left  <= n_left;
            r_done  <= n_done;
        end
    end

endmodule

@@ rtl/rld_queue.sv @@
// ----------------------------------------------------------------------------
// rld_queue
// Short command queue that decouples the parser from the expander.
// ----------------------------------------------------------------------------
module rld_queue
    import rld_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);

    t_cmd            r_mem [QDEPTH];
    logic [QAW-1:0]  r_wptr, r_rptr;
    logic [QCW-1:0]  r_count;

    function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
        ptr_inc = (p == QAW'(QDEPTH - 1)) ? '0 : p + QAW'(1);
    endfunction

    assign o_stat.full  = (r_count == QCW'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= ptr_inc(r_wptr);
            if (i_pop)  r_rptr <= ptr_inc(r_rptr);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/rld_back.sv @@
// ----------------------------------------------------------------------------
// rld_back
// Expands queued commands into output transfers, one byte per cycle while i_out_ready is high.
// ----------------------------------------------------------------------------
module rld_back
    import rld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_head,
    input  t_qstat               i_qstat,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_has_data,
    output logic [BYTE_BITS-1:0] o_data_byte,
    output logic                 o_end_of_stream,
    output logic                 o_last
);

    logic                 r_busy;
    logic                 r_has;
    logic [BYTE_BITS-1:0] r_data;
    logic [CNT_W-1:0]     r_left;
    logic                 r_eos;
    logic                 final_one;
    logic                 out_fire;

    assign final_one = (r_left == CNT_W'(1));
    assign out_fire  = r_busy & i_out_ready;

    // Load the next command when idle or when the current one finishes
    assign o_pop = ~i_qstat.empty & (~r_busy | (out_fire & final_one));

    assign o_out_valid     = r_busy;
    assign o_has_data      = r_has;
    assign o_data_byte     = r_data;
    assign o_last          = final_one;
    assign o_end_of_stream = r_eos & final_one;

    // Busy flag and remaining count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_left <= i_head.count;
        end else if (out_fire) begin
            r_left <= r_left - CNT_W'(1);
            if (final_one) r_busy <= 1'b0;
        end
    end

    // Payload of the command being expanded
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_has  <= i_head.has_data;
            r_data <= i_head.data;
            r_eos  <= i_head.eos;
        end
    end

endmodule

@@ rtl/bit_packed_rle_decoder.sv @@
// ----------------------------------------------------------------------------
// bit_packed_rle_decoder
// Bit-aligned run-length decoder: compressed bytes in, decoded bytes out.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   input   | in        | i_in_valid / o_in_ready   | i_code_byte
//   output  | out       | o_out_valid / i_out_ready | o_has_data, o_data_byte,
//           |           |                           | o_end_of_stream, o_last
//
// A compressed byte is parsed on transfer; its command enters the queue and is
// then loaded into the expander registers. One output byte leaves per cycle
// while i_out_ready is high; a run of N copies holds the expander until all N
// are out. Input flows until the two-entry queue fills, then o_in_ready drops.
// Reset is synchronous, active low; no clearing pass, input ready on release.
// After the end marker every input byte is taken and dropped until reset.
// ----------------------------------------------------------------------------
module bit_packed_rle_decoder
    import rld_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [BYTE_BITS-1:0] i_code_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_has_data,
    output logic [BYTE_BITS-1:0] o_data_byte,
    output logic                 o_end_of_stream,
    output logic                 o_last
);

    logic   push;
    logic   pop;
    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;

    // Token parser
    rld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_code_byte (i_code_byte),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Command queue
    rld_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (qstat)
    );

    // Run expander and output register
    rld_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_cmd),
        .i_qstat         (qstat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_has_data      (o_has_data),
        .o_data_byte     (o_data_byte),
        .o_end_of_stream (o_end_of_stream),
        .o_last          (o_last)
    );

endmodule

@@ rtl/rld_checker.sv @@
// ----------------------------------------------------------------------------
// rld_checker
// Port-level checks of the decoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module rld_checker
    import rld_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic [BYTE_BITS-1:0] i_code_byte,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_has_data,
    input logic [BYTE_BITS-1:0] o_data_byte,
    input logic                 o_end_of_stream,
    input logic                 o_last
);

    // A stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_byte)
            && $stable(o_last) && $stable(o_end_of_stream))
        else $error("output payload changed while stalled");

    // End of stream only on the final result of a command
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_stream |-> o_last)
        else $error("end_of_stream without last");

    // A result with no data is the end-only marker
    a_nodata_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_end_of_stream && (o_data_byte == '0))
        else $error("empty result that is not the end marker");

    // Nothing follows the end of stream, and input is drained freely
    a_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_end_of_stream |=> !o_out_valid && o_in_ready)
        else $error("activity after end of stream");

endmodule

bind bit_packed_rle_decoder rld_checker u_rld_checker (.*);
